/* design/fvst_pkg.sv */
// ----------------------------------------------------------------------------
// fvst_pkg: shared definitions for the frame step timer
// Field widths, register indexes, reset values and the status word of the
// bit-serial arithmetic units.
// ----------------------------------------------------------------------------
package fvst_pkg;

  // field widths
  localparam int FREQ_W     = 40;
  localparam int COUNT_W    = 63;
  localparam int TGT_W      = 24;
  localparam int TICK_W     = 24;
  localparam int LEFT_W     = 25;
  localparam int ACC_W      = 64;
  localparam int TOTAL_W    = 64;
  localparam int FRAME_W    = 32;
  localparam int STEPS_W    = 20;
  localparam int FPS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // clamped delta is at most 2^40 / 10, which fits 37 bits
  localparam int DCLAMP_W   = 37;
  localparam int PROD_W     = 64;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

  // constants
  localparam int DEF_TICKS_PER_SECOND = 10000000;
  localparam int CLAMP_DIVISOR        = 10;
  localparam int SNAP_DIVISOR         = 4000;

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(10000000);
  localparam logic [TGT_W-1:0]  TGT_RESET  = TGT_W'(166667);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ   = 2'd0,
    REG_START  = 2'd1,
    REG_MODE   = 2'd2,
    REG_TARGET = 2'd3
  } cfg_reg_t;

  // status of a bit-serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* design/fvst_if.sv */
// ----------------------------------------------------------------------------
// fvst_if: channel interfaces of the frame step timer
// Sample channel, result channel and configuration write channel, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
interface fvst_sample_if;
  logic                           valid;
  logic                           ready;
  logic [fvst_pkg::COUNT_W-1:0]   counter_now;

  modport source (output valid, output counter_now, input ready);
  modport sink   (input valid, input counter_now, output ready);
endinterface

interface fvst_result_if;
  logic                           valid;
  logic                           ready;
  logic [fvst_pkg::TICK_W-1:0]    elapsed_ticks;
  logic [fvst_pkg::TOTAL_W-1:0]   total_ticks;
  logic [fvst_pkg::FRAME_W-1:0]   frame_count;
  logic [fvst_pkg::STEPS_W-1:0]   frames_stepped;
  logic [fvst_pkg::FPS_W-1:0]     frames_per_second;

  modport source (output valid, output elapsed_ticks, output total_ticks,
                  output frame_count, output frames_stepped,
                  output frames_per_second, input ready);
  modport sink   (input valid, input elapsed_ticks, input total_ticks,
                  input frame_count, input frames_stepped,
                  input frames_per_second, output ready);
endinterface

interface fvst_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fvst_pkg::CFG_IDX_W-1:0]    index;
  logic [fvst_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/fvst_div.sv */
// ----------------------------------------------------------------------------
// fvst_div: bit-serial restoring divider
// Takes one quotient bit per cycle from the top of a left-aligned dividend.
// Produces nbits quotient bits; the quotient ends in the low bits of the shift register.
// ----------------------------------------------------------------------------
module fvst_div #(
  parameter int DVD_W = 64,
  parameter int DVS_W = 40
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [DVS_W-1:0]             divisor,
  input  logic [$clog2(DVD_W+1)-1:0]   nbits,
  output fvst_pkg::unit_stat_t         stat,
  output logic [DVD_W-1:0]             quotient,
  output logic [DVS_W-1:0]             remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DVS_W:0]   partial;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  // one trial subtract per cycle
  always_comb begin
    partial  = {rem, dvd[DVD_W-1]};
    diff     = partial - {1'b0, dvs};
    fits     = (partial >= {1'b0, dvs});
    rem_next = fits ? diff[DVS_W-1:0] : partial[DVS_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* design/fvst_mul.sv */
// ----------------------------------------------------------------------------
// fvst_mul: bit-serial shift-and-add multiplier
// Walks the multiplier MSB first, one bit per cycle, doubling the product
// and adding the multiplicand when the bit is set.
// ----------------------------------------------------------------------------
module fvst_mul #(
  parameter int A_W = 37,
  parameter int B_W = 24,
  parameter int P_W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output fvst_pkg::unit_stat_t stat,
  output logic [P_W-1:0]       product
);

  localparam int CNT_W = $clog2(A_W + 1);

  logic [A_W-1:0]   a_sh;
  logic [B_W-1:0]   b_r;
  logic [P_W-1:0]   acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(A_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_sh <= a;
      b_r  <= b;
      acc  <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[A_W-2:0], 1'b0};
      acc  <= {acc[P_W-2:0], 1'b0} + (a_sh[A_W-1] ? P_W'(b_r) : '0);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

/* design/fixed_or_variable_frame_step_timer_top.sv */
// ----------------------------------------------------------------------------
// fixed_or_variable_frame_step_timer_top: game loop step timer
// Turns counter samples into frame steps in fixed or variable timestep mode.
// ----------------------------------------------------------------------------
// Each sample word carries a free-running counter value; the block answers
// it with one result word. One sample is worked at a time. The sequencer
// runs a single bit-serial divider in turn for the clamp (frequency / 10),
// the tick conversion and, in fixed mode with a nonzero target, the
// fixed-step split, with a bit-serial multiply between. A second divider
// reduces the one-second accumulator in parallel. The next sample is taken
// as soon as the sequencer is back in idle, even while the last result word
// still waits to be taken; a new result word waits in the sequencer until
// the previous one is taken. A counter_frequency of zero counts as one.
// Configuration writes are taken only while the sequencer is idle, ahead of
// a sample offered in the same cycle; a start_count write reloads the
// reference sample.
// ----------------------------------------------------------------------------
module fixed_or_variable_frame_step_timer_top #(
  parameter int TICKS_PER_SECOND = fvst_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic          clk,
  input  logic          rst,
  fvst_sample_if.sink   sample,
  fvst_result_if.source result,
  fvst_cfg_if.sink      cfg
);

  localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int SNAP  = TICKS_PER_SECOND / fvst_pkg::SNAP_DIVISOR;

  localparam logic [fvst_pkg::STEPS_W-1:0] STEPS_MAX = '1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_MAXD = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIVT = 7'b0010000,
    S_DIVL = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [fvst_pkg::FREQ_W-1:0]  freq;
  logic                         fixed_mode;
  logic [fvst_pkg::TGT_W-1:0]   tgt;
  logic [fvst_pkg::FREQ_W-1:0]  freq_eff;

  // timer state
  logic [fvst_pkg::COUNT_W-1:0] last_count;
  logic [fvst_pkg::ACC_W-1:0]   sec_acc;
  logic [fvst_pkg::LEFT_W-1:0]  leftover;
  logic [fvst_pkg::TICK_W-1:0]  step_ticks;
  logic [fvst_pkg::TOTAL_W-1:0] tick_total;
  logic [fvst_pkg::FRAME_W-1:0] frame_total;
  logic [fvst_pkg::FRAME_W-1:0] frames_in_sec;
  logic [fvst_pkg::FPS_W-1:0]   fps;

  // per-sample work registers
  logic [fvst_pkg::COUNT_W-1:0] delta;
  logic [fvst_pkg::LEFT_W-1:0]  steps;
  logic                         stepped;

  // output register
  logic                          out_valid;
  logic [fvst_pkg::TICK_W-1:0]   out_elapsed;
  logic [fvst_pkg::TOTAL_W-1:0]  out_total;
  logic [fvst_pkg::FRAME_W-1:0]  out_frames;
  logic [fvst_pkg::STEPS_W-1:0]  out_stepped;
  logic [fvst_pkg::FPS_W-1:0]    out_fps;

  // divider A: clamp, tick conversion, fixed-step split
  logic                            da_start;
  logic [fvst_pkg::PROD_W-1:0]     da_dividend;
  logic [fvst_pkg::FREQ_W-1:0]     da_divisor;
  logic [fvst_pkg::DIV_CNT_W-1:0]  da_nbits;
  fvst_pkg::unit_stat_t            da_stat;
  logic [fvst_pkg::PROD_W-1:0]     da_q;
  logic [fvst_pkg::FREQ_W-1:0]     da_r;

  // divider B: second accumulator modulo frequency
  logic                            db_start;
  fvst_pkg::unit_stat_t            db_stat;
  logic [fvst_pkg::ACC_W-1:0]      db_q;
  logic [fvst_pkg::FREQ_W-1:0]     db_r;

  // multiplier: clamped delta times ticks per second
  logic                            mul_start;
  logic [fvst_pkg::DCLAMP_W-1:0]   dclamp;
  fvst_pkg::unit_stat_t            mul_stat;
  logic [fvst_pkg::PROD_W-1:0]     product;

  // combinational helpers
  logic [fvst_pkg::ACC_W-1:0]      acc_sum;
  logic [fvst_pkg::DCLAMP_W-1:0]   max_delta;
  logic [fvst_pkg::TICK_W-1:0]     ticks;
  logic [fvst_pkg::TGT_W-1:0]      tick_diff;
  logic [fvst_pkg::TICK_W-1:0]     ticks_snap;
  logic [fvst_pkg::LEFT_W-1:0]     left_sum;
  logic [fvst_pkg::LEFT_W-1:0]     split_q;
  logic [fvst_pkg::LEFT_W-1:0]     split_r;
  logic [fvst_pkg::FRAME_W-1:0]    fis_inc;
  logic                            sec_wrap;
  logic [fvst_pkg::FPS_W-1:0]      fps_new;
  logic                            out_free;
  logic                            out_load;

  assign freq_eff  = (freq == '0) ? fvst_pkg::FREQ_W'(1) : freq;
  assign acc_sum   = sec_acc + fvst_pkg::ACC_W'(delta);
  assign max_delta = da_q[fvst_pkg::DCLAMP_W-1:0];
  assign dclamp    = (delta > fvst_pkg::COUNT_W'(max_delta)) ?
                     max_delta : delta[fvst_pkg::DCLAMP_W-1:0];
  assign ticks     = da_q[fvst_pkg::TICK_W-1:0];
  assign tick_diff = (ticks >= tgt) ? (ticks - tgt) : (tgt - ticks);
  assign ticks_snap = (tick_diff < fvst_pkg::TGT_W'(SNAP)) ? tgt : ticks;
  assign left_sum  = leftover + fvst_pkg::LEFT_W'(ticks_snap);
  assign split_q   = da_q[fvst_pkg::LEFT_W-1:0];
  assign split_r   = {1'b0, da_r[fvst_pkg::TGT_W-1:0]};
  assign fis_inc   = frames_in_sec + fvst_pkg::FRAME_W'(stepped);
  assign sec_wrap  = (sec_acc >= fvst_pkg::ACC_W'(freq_eff));
  assign fps_new   = sec_wrap ? fis_inc : fps;
  assign out_free  = !out_valid || result.ready;
  assign out_load  = (state == S_DONE) && !db_stat.busy && out_free;

  // unit start requests and operand selection
  always_comb begin
    da_start    = 1'b0;
    da_dividend = '0;
    da_divisor  = fvst_pkg::FREQ_W'(fvst_pkg::CLAMP_DIVISOR);
    da_nbits    = fvst_pkg::DIV_CNT_W'(fvst_pkg::FREQ_W);
    db_start    = 1'b0;
    mul_start   = 1'b0;
    case (state)
      S_PREP: begin
        da_start    = 1'b1;
        da_dividend = {freq_eff, {(fvst_pkg::PROD_W - fvst_pkg::FREQ_W){1'b0}}};
        db_start    = 1'b1;
      end
      S_MAXD: begin
        mul_start = da_stat.done;
      end
      S_MUL: begin
        da_start    = mul_stat.done;
        da_dividend = product;
        da_divisor  = freq_eff;
        da_nbits    = fvst_pkg::DIV_CNT_W'(fvst_pkg::PROD_W);
      end
      S_DIVT: begin
        da_start    = da_stat.done && fixed_mode && (tgt != '0);
        da_dividend = {left_sum, {(fvst_pkg::PROD_W - fvst_pkg::LEFT_W){1'b0}}};
        da_divisor  = fvst_pkg::FREQ_W'(tgt);
        da_nbits    = fvst_pkg::DIV_CNT_W'(fvst_pkg::LEFT_W);
      end
      default: begin
      end
    endcase
  end

  fvst_div #(
    .DVD_W (fvst_pkg::PROD_W),
    .DVS_W (fvst_pkg::FREQ_W)
  ) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .start     (da_start),
    .dividend  (da_dividend),
    .divisor   (da_divisor),
    .nbits     (da_nbits),
    .stat      (da_stat),
    .quotient  (da_q),
    .remainder (da_r)
  );

  fvst_div #(
    .DVD_W (fvst_pkg::ACC_W),
    .DVS_W (fvst_pkg::FREQ_W)
  ) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .start     (db_start),
    .dividend  (acc_sum),
    .divisor   (freq_eff),
    .nbits     (fvst_pkg::DIV_CNT_W'(fvst_pkg::ACC_W)),
    .stat      (db_stat),
    .quotient  (db_q),
    .remainder (db_r)
  );

  fvst_mul #(
    .A_W (fvst_pkg::DCLAMP_W),
    .B_W (TPS_W),
    .P_W (fvst_pkg::PROD_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (dclamp),
    .b       (TPS_W'(TICKS_PER_SECOND)),
    .stat    (mul_stat),
    .product (product)
  );

  // channel handshakes: register writes only between samples, ahead of one
  assign sample.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready    = (state == S_IDLE);

  // sequencer and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      freq          <= fvst_pkg::FREQ_RESET;
      fixed_mode    <= 1'b0;
      tgt           <= fvst_pkg::TGT_RESET;
      last_count    <= '0;
      sec_acc       <= '0;
      leftover      <= '0;
      step_ticks    <= '0;
      tick_total    <= '0;
      frame_total   <= '0;
      frames_in_sec <= '0;
      fps           <= '0;
      stepped       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      // configuration write
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          fvst_pkg::REG_FREQ:   freq       <= cfg.data[fvst_pkg::FREQ_W-1:0];
          fvst_pkg::REG_START:  last_count <= cfg.data[fvst_pkg::COUNT_W-1:0];
          fvst_pkg::REG_MODE:   fixed_mode <= cfg.data[0];
          fvst_pkg::REG_TARGET: tgt        <= cfg.data[fvst_pkg::TGT_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (sample.valid && sample.ready) begin
            delta      <= sample.counter_now - last_count;
            last_count <= sample.counter_now;
            state      <= S_PREP;
          end
        end
        S_PREP: begin
          sec_acc <= acc_sum;
          state   <= S_MAXD;
        end
        S_MAXD: begin
          if (da_stat.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            state <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (da_stat.done) begin
            if (!fixed_mode) begin
              // variable step: one frame of the whole tick count
              step_ticks  <= ticks;
              tick_total  <= tick_total + fvst_pkg::TOTAL_W'(ticks);
              leftover    <= '0;
              frame_total <= frame_total + fvst_pkg::FRAME_W'(1);
              steps       <= fvst_pkg::LEFT_W'(1);
              stepped     <= 1'b1;
              state       <= S_DONE;
            end else if (tgt == '0) begin
              leftover <= '0;
              steps    <= '0;
              stepped  <= 1'b0;
              state    <= S_DONE;
            end else begin
              leftover <= left_sum;
              state    <= S_DIVL;
            end
          end
        end
        S_DIVL: begin
          if (da_stat.done) begin
            // whole target steps out of the leftover
            steps    <= split_q;
            leftover <= split_r;
            stepped  <= (split_q != '0);
            if (split_q != '0) begin
              step_ticks  <= tgt;
              tick_total  <= tick_total + fvst_pkg::TOTAL_W'(leftover - split_r);
              frame_total <= frame_total + fvst_pkg::FRAME_W'(split_q);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            // one-second frame rate window
            if (sec_wrap) begin
              fps           <= fis_inc;
              frames_in_sec <= '0;
              sec_acc       <= fvst_pkg::ACC_W'(db_r);
            end else begin
              frames_in_sec <= fis_inc;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_elapsed <= step_ticks;
      out_total   <= tick_total;
      out_frames  <= frame_total;
      out_stepped <= (steps > fvst_pkg::LEFT_W'(STEPS_MAX)) ?
                     STEPS_MAX : steps[fvst_pkg::STEPS_W-1:0];
      out_fps     <= fps_new;
    end
  end

  assign result.valid             = out_valid;
  assign result.elapsed_ticks     = out_elapsed;
  assign result.total_ticks       = out_total;
  assign result.frame_count       = out_frames;
  assign result.frames_stepped    = out_stepped;
  assign result.frames_per_second = out_fps;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the frame step timer
// Drives counter sample words and register writes through the valid/ready
// channels. A local model of the timer predicts every result word; each word
// is compared field by field in arrival order with the prediction or, for a
// directed row with a typed result, with that typed word. A short directed
// table opens the run, then random phases follow, each under its own register setting.
module testbench;

  localparam longint unsigned TPS        = fvst_pkg::DEF_TICKS_PER_SECOND;
  localparam logic [63:0]     MAX63      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]     MAX40      = 64'h00FF_FFFF_FFFF;
  localparam int              PHASES     = 8;
  localparam int              PHASE_LEN  = 112;
  localparam int              SETTLE_CYC = 200;

  // one result word
  typedef struct packed {
    logic [fvst_pkg::TICK_W-1:0]  elapsed;
    logic [fvst_pkg::TOTAL_W-1:0] total;
    logic [fvst_pkg::FRAME_W-1:0] frames;
    logic [fvst_pkg::STEPS_W-1:0] stepped;
    logic [fvst_pkg::FPS_W-1:0]   fps;
  } step_word_t;

  // directed row: register write or sample, with an optional typed result
  typedef struct packed {
    logic                is_reg;
    fvst_pkg::cfg_reg_t  idx;
    logic [63:0]         value;
    logic                typed;
    step_word_t          word;
  } plan_row_t;

  localparam step_word_t NO_WORD = '0;

  localparam plan_row_t DIRECTED_PLAN [31] = '{
    // after reset: variable mode, 10 MHz counter
    '{1'b0, fvst_pkg::REG_FREQ, 64'd0, 1'b1, '{24'd0, 64'd0, 32'd1, 20'd1, 32'd0}},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd166667, 1'b1,
      '{24'd166667, 64'd166667, 32'd2, 20'd1, 32'd0}},
    // long frame: clamped to a tenth of a second, one second completes
    '{1'b0, fvst_pkg::REG_FREQ, 64'd10166667, 1'b1,
      '{24'd1000000, 64'd1166667, 32'd3, 20'd1, 32'd3}},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd10166667, 1'b1,
      '{24'd0, 64'd1166667, 32'd4, 20'd1, 32'd3}},
    // counter wrap across the top of the 63-bit range
    '{1'b1, fvst_pkg::REG_START, MAX63, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd999, 1'b1,
      '{24'd1000, 64'd1167667, 32'd5, 20'd1, 32'd3}},
    // fixed mode: snap, no step, step with leftover
    '{1'b1, fvst_pkg::REG_MODE, 64'd1, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd168666, 1'b1,
      '{24'd166667, 64'd1334334, 32'd6, 20'd1, 32'd3}},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd268666, 1'b1,
      '{24'd166667, 64'd1334334, 32'd6, 20'd0, 32'd3}},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd368666, 1'b1,
      '{24'd166667, 64'd1501001, 32'd7, 20'd1, 32'd3}},
    // zero target clears leftover and takes no step
    '{1'b1, fvst_pkg::REG_TARGET, 64'd0, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd418666, 1'b1,
      '{24'd166667, 64'd1501001, 32'd7, 20'd0, 32'd3}},
    // one-tick target: a million steps on one sample
    '{1'b1, fvst_pkg::REG_TARGET, 64'd1, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd1418666, 1'b1,
      '{24'd1, 64'd2501001, 32'd1000007, 20'd1000000, 32'd3}},
    // zero frequency counts as one: no ticks, snapped to target, latch
    '{1'b1, fvst_pkg::REG_FREQ, 64'd0, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd1418671, 1'b1,
      '{24'd1, 64'd2501002, 32'd1000008, 20'd1, 32'd6}},
    // widest frequency, all-ones and all-zeros samples
    '{1'b1, fvst_pkg::REG_FREQ, MAX40, 1'b0, NO_WORD},
    '{1'b1, fvst_pkg::REG_MODE, 64'd0, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, MAX63, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd0, 1'b0, NO_WORD},
    '{1'b1, fvst_pkg::REG_TARGET, 64'hFF_FFFF, 1'b0, NO_WORD},
    '{1'b1, fvst_pkg::REG_MODE, 64'd1, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'h2AAA_AAAA_AAAA_AAAA, 1'b0, NO_WORD},
    // snap window edges around a 60 Hz target
    '{1'b1, fvst_pkg::REG_FREQ, 64'd10000000, 1'b0, NO_WORD},
    '{1'b1, fvst_pkg::REG_TARGET, 64'd166667, 1'b0, NO_WORD},
    '{1'b1, fvst_pkg::REG_START, 64'd0, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd166666, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd335832, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd504999, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd669167, 1'b0, NO_WORD},
    '{1'b0, fvst_pkg::REG_FREQ, 64'd833334, 1'b0, NO_WORD}
  };

  logic clk;
  logic rst = 1'b1;
  bit   idle_on;
  int   mismatch_count;

  fvst_sample_if sample_ch ();
  fvst_result_if result_ch ();
  fvst_cfg_if    cfg_ch ();

  fixed_or_variable_frame_step_timer_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // register copies and timer state of the local model
  logic [fvst_pkg::FREQ_W-1:0]  freq_reg;
  logic [fvst_pkg::COUNT_W-1:0] start_reg;
  logic                         fixed_reg;
  logic [fvst_pkg::TGT_W-1:0]   target_reg;
  logic [fvst_pkg::COUNT_W-1:0] last_count;
  logic [63:0]                  sec_acc;
  logic [63:0]                  leftover;
  logic [fvst_pkg::TICK_W-1:0]  step_ticks;
  logic [63:0]                  tick_total;
  logic [31:0]                  frame_total;
  logic [31:0]                  frames_in_sec;
  logic [31:0]                  fps_latched;

  step_word_t pending_steps [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic step_word_t advance_frame_timer(
    input logic [fvst_pkg::COUNT_W-1:0] now
  );
    logic [63:0] freq;
    logic [63:0] delta;
    logic [63:0] max_delta;
    logic [63:0] ticks;
    logic [63:0] tgt;
    logic [63:0] diff;
    logic [63:0] steps;
    logic        stepped;
    step_word_t  w;
    freq      = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
    delta     = {1'b0, now - last_count};
    max_delta = freq / 64'd10;
    steps     = '0;
    stepped   = 1'b0;
    last_count = now;
    sec_acc    = sec_acc + delta;
    if (delta > max_delta) delta = max_delta;
    ticks = (delta * TPS) / freq;
    if (fixed_reg) begin
      tgt  = 64'(target_reg);
      diff = (ticks >= tgt) ? ticks - tgt : tgt - ticks;
      if (diff < TPS / 64'd4000) ticks = tgt;
      if (tgt == '0) begin
        leftover = '0;
      end else begin
        leftover = leftover + ticks;
        steps    = leftover / tgt;
        if (steps != '0) begin
          step_ticks  = target_reg;
          tick_total  = tick_total + steps * tgt;
          leftover    = leftover - steps * tgt;
          frame_total = frame_total + steps[31:0];
          stepped     = 1'b1;
        end
      end
    end else begin
      step_ticks  = ticks[fvst_pkg::TICK_W-1:0];
      tick_total  = tick_total + ticks;
      leftover    = '0;
      frame_total = frame_total + 32'd1;
      steps       = 64'd1;
      stepped     = 1'b1;
    end
    if (stepped) frames_in_sec = frames_in_sec + 32'd1;
    // one full second of counts latches the frame rate
    if (sec_acc >= freq) begin
      fps_latched   = frames_in_sec;
      frames_in_sec = '0;
      sec_acc       = sec_acc % freq;
    end
    w.elapsed = step_ticks;
    w.total   = tick_total;
    w.frames  = frame_total;
    w.stepped = (steps > 64'hF_FFFF) ? '1 : steps[fvst_pkg::STEPS_W-1:0];
    w.fps     = fps_latched;
    return w;
  endfunction

  // next counter delta, mostly near the target frame length
  function automatic logic [fvst_pkg::COUNT_W-1:0] pick_delta();
    logic [63:0]  freq;
    logic [63:0]  win;
    logic [63:0]  nominal;
    logic [127:0] prod;
    freq    = (freq_reg == '0) ? 64'd1 : 64'(freq_reg);
    prod    = 128'(freq) * 128'(target_reg);
    nominal = 64'(prod / 128'(TPS));
    win     = freq / 64'd4000;
    case ($urandom_range(0, 9)) inside
      [0:5]: begin
        return fvst_pkg::COUNT_W'(nominal + ({$urandom, $urandom} % (2 * win + 3))
                                  - (win + 1));
      end
      6: return fvst_pkg::COUNT_W'({$urandom, $urandom} % (freq / 64'd10 + 1));
      7: return fvst_pkg::COUNT_W'($urandom_range(0, 3));
      8: return fvst_pkg::COUNT_W'({$urandom, $urandom});
      default: return fvst_pkg::COUNT_W'({$urandom, $urandom} % (2 * freq + 1));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // stop offering samples and wait for every result word
  task automatic settle_pending();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input fvst_pkg::cfg_reg_t idx, input logic [63:0] data);
    settle_pending();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      fvst_pkg::REG_FREQ:   freq_reg = data[fvst_pkg::FREQ_W-1:0];
      fvst_pkg::REG_START: begin
        start_reg  = data[fvst_pkg::COUNT_W-1:0];
        last_count = start_reg;
      end
      fvst_pkg::REG_MODE:   fixed_reg = data[0];
      fvst_pkg::REG_TARGET: target_reg = data[fvst_pkg::TGT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // valid stays high between back-to-back words; a gap lowers it first
  task automatic send_sample(input logic [fvst_pkg::COUNT_W-1:0] now, input bit typed,
                             input step_word_t typed_word);
    step_word_t predicted;
    int         gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      sample_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_ch.valid       <= 1'b1;
    sample_ch.counter_now <= now;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = advance_frame_timer(now);
    pending_steps.push_back(typed ? typed_word : predicted);
  endtask

  // result side back-pressure
  initial begin
    int stall_left;
    result_ch.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    step_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_steps.size() == 0) begin
        flag_error("result word with no sample pending");
      end else begin
        want = pending_steps.pop_front();
        check_field("elapsed_ticks", 64'(result_ch.elapsed_ticks), 64'(want.elapsed));
        check_field("total_ticks", result_ch.total_ticks, want.total);
        check_field("frame_count", 64'(result_ch.frame_count), 64'(want.frames));
        check_field("frames_stepped", 64'(result_ch.frames_stepped), 64'(want.stepped));
        check_field("frames_per_second", 64'(result_ch.frames_per_second), 64'(want.fps));
      end
    end
  end

  initial begin
    logic [63:0]                  f;
    logic [63:0]                  st;
    logic [63:0]                  tg;
    logic                         md;
    logic [fvst_pkg::COUNT_W-1:0] counter_val;
    sample_ch.valid       = 1'b0;
    sample_ch.counter_now = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = fvst_pkg::REG_FREQ;
    cfg_ch.data           = '0;
    mismatch_count        = 0;
    idle_on               = 1'b1;
    freq_reg      = fvst_pkg::FREQ_RESET;
    start_reg     = '0;
    fixed_reg     = 1'b0;
    target_reg    = fvst_pkg::TGT_RESET;
    last_count    = '0;
    sec_acc       = '0;
    leftover      = '0;
    step_ticks    = '0;
    tick_total    = '0;
    frame_total   = '0;
    frames_in_sec = '0;
    fps_latched   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed part
    foreach (DIRECTED_PLAN[k]) begin
      if (DIRECTED_PLAN[k].is_reg)
        write_reg(DIRECTED_PLAN[k].idx, DIRECTED_PLAN[k].value);
      else
        send_sample(DIRECTED_PLAN[k].value[fvst_pkg::COUNT_W-1:0], DIRECTED_PLAN[k].typed,
                    DIRECTED_PLAN[k].word);
    end

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          f = 64'd10000000; md = 1'b1; tg = 64'd166667;
        end
        1: begin
          f = 64'd10000000; md = 1'b0; tg = 64'($urandom_range(1, 10000000));
        end
        2: begin
          f = MAX40; md = 1'b1; tg = 64'($urandom_range(1, 4));
        end
        3: begin
          f = 64'd1; md = 1'b1; tg = 64'($urandom_range(1, 5000));
        end
        4: begin
          f = {$urandom, $urandom} & MAX40; md = 1'b1; tg = 64'hFF_FFFF;
        end
        5: begin
          f = 64'd0; md = 1'b0; tg = 64'd0;
        end
        6: begin
          f  = 64'($urandom_range(1000, 1000000000));
          md = 1'b1;
          tg = 64'($urandom_range(0, 1000000));
        end
        default: begin
          f = 64'd10000000; md = 1'b1; tg = 64'd333333;
        end
      endcase
      // half the phases start just under the wrap point
      if ($urandom_range(0, 1) == 1)
        st = MAX63 - 64'($urandom_range(0, 100000000));
      else
        st = {$urandom, $urandom} & MAX63;
      write_reg(fvst_pkg::REG_FREQ, f);
      write_reg(fvst_pkg::REG_START, st);
      write_reg(fvst_pkg::REG_MODE, 64'(md));
      write_reg(fvst_pkg::REG_TARGET, tg);
      idle_on     = (ph != 3) && (ph != PHASES - 1);
      counter_val = st[fvst_pkg::COUNT_W-1:0];
      for (int n = 0; n < PHASE_LEN; n++) begin
        counter_val = counter_val + pick_delta();
        send_sample(counter_val, 1'b0, NO_WORD);
      end
    end

    settle_pending();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
